// ===== rtl/core/sac_pkg.sv =====
// Shared types and constants for the set-associative cache LRU simulator.
// No dependencies.
package sac_pkg;

    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_STAMP_WIDTH  = 32;

    localparam int ADDR_W  = 64;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS        = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the access and issue the set read
        logic lookup;  // compare, pick, write back, report
        logic last;    // this lookup ends the item
        logic tick;    // advance the access clock
    } t_dp_cmd;

endpackage

// ===== rtl/core/sac_ctrl.sv =====
// Controller state machine: sequences one or two lookups per item.
// Depends on sac_pkg.
module sac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_command,
    input  logic             i_init,
    output logic             o_busy,
    output sac_pkg::t_dp_cmd o_cmd
);
    import sac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_LOOK1, S_READ2, S_LOOK2
    } t_state;

    t_state r_state, n_state;
    logic   r_modify;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && !i_init && i_command != CMD_NONE) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK1;
                end
            end
            S_LOOK1: begin
                o_cmd.lookup = 1'b1;
                o_cmd.last   = !r_modify;
                o_cmd.tick   = !r_modify;
                n_state      = r_modify ? S_READ2 : S_IDLE;
            end
            S_READ2: begin
                n_state = S_LOOK2;
            end
            S_LOOK2: begin
                o_cmd.lookup = 1'b1;
                o_cmd.last   = 1'b1;
                o_cmd.tick   = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Busy while an item is in flight or the valid store is being cleared.
    assign o_busy = (r_state != S_IDLE) || i_init;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_modify <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_modify <= (i_command == CMD_MODIFY);
        end
    end

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |-> o_busy) else $error("lookup while idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_LOOK1)) else $error("load did not enter lookup");
    a_read2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ2) |=> (r_state == S_LOOK2)) else $error("second pass lost");

endmodule

// ===== rtl/core/sac_dp.sv =====
// Datapath: tag, stamp and valid stores, compare, LRU pick, totals.
// Depends on sac_pkg.
module sac_dp #(
    parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sac_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = sac_pkg::DEF_STAMP_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sac_pkg::t_dp_cmd                i_cmd,
    input  logic [63:0]                     i_address,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_init,
    output logic                            o_valid,
    output logic [1:0]                      o_outcome,
    output logic                            o_last,
    output logic [sac_pkg::TOTAL_W-1:0]     o_hits,
    output logic [sac_pkg::TOTAL_W-1:0]     o_misses,
    output logic [sac_pkg::TOTAL_W-1:0]     o_evictions
);
    import sac_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SI_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;
    localparam logic [TOTAL_W-1:0]     TOT_MAX   = '1;

    // Configuration registers.
    logic [3:0] r_set_bits, r_ways;
    logic [4:0] r_off_bits;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= 4'd4;
            r_ways     <= 4'd1;
            r_off_bits <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SET_BITS:    r_set_bits <= i_cfg_data[3:0];
                REG_WAYS:        r_ways     <= i_cfg_data[3:0];
                REG_OFFSET_BITS: r_off_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry, clamped.
    logic [4:0]        s_eff;
    logic [4:0]        b_eff;
    logic [WCNT_W:0]   w_eff;
    always_comb begin
        s_eff = ({1'b0, r_set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                         : {1'b0, r_set_bits};
        b_eff = (r_off_bits > 5'd16) ? 5'd16 : r_off_bits;
        if (r_ways == 4'd0) w_eff = (WCNT_W+1)'(1);
        else if (32'(r_ways) > MAX_WAYS) w_eff = (WCNT_W+1)'(MAX_WAYS);
        else w_eff = (WCNT_W+1)'(r_ways);
    end

    // Access latch: tag and set split on load.
    logic [63:0]     r_tag;
    logic [SI_W-1:0] r_set;
    logic [63:0]     shifted;
    logic [SI_W-1:0] ld_set;
    always_comb shifted = i_address >> b_eff;
    assign ld_set = SI_W'(shifted & ~(64'hFFFF_FFFF_FFFF_FFFF << s_eff));
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= shifted >> s_eff;
            r_set <= ld_set;
        end
    end

    // Access clock; its value is the stamp written by every lookup.
    logic [STAMP_WIDTH-1:0] r_clock;

    // Per-way stores; each way is a memory indexed by set.
    logic [63:0]            r_tagq  [MAX_WAYS];
    logic [STAMP_WIDTH-1:0] r_stq   [MAX_WAYS];
    logic [MAX_WAYS-1:0]    r_vq;
    logic                   wr_en;
    logic [WAY_W-1:0]       wr_way;
    logic [MAX_WAYS-1:0]    wr_mask;
    logic [SI_W-1:0]        rd_set;

    // The set read is issued together with the access latch, and again
    // before the second pass so that it sees the first pass's write.
    assign rd_set = i_cmd.load ? ld_set : r_set;

    for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
        logic [63:0]            mem_tag [SETS];
        logic [STAMP_WIDTH-1:0] mem_st  [SETS];
        always_ff @(posedge i_clk) begin
            if (wr_en && wr_way == WAY_W'(w)) begin
                mem_tag[r_set] <= r_tag;
                mem_st[r_set]  <= r_clock;
            end
            r_tagq[w] <= mem_tag[rd_set];
            r_stq[w]  <= mem_st[rd_set];
        end
    end

    // Valid store: one word of way flags per set, cleared one set per
    // cycle after reset.
    logic [MAX_WAYS-1:0] mem_valid [SETS];
    logic [SI_W-1:0]     r_clr_idx;
    logic                r_clearing;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == SI_W'(SETS - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) mem_valid[r_clr_idx] <= '0;
        else if (wr_en) mem_valid[r_set] <= r_vq | wr_mask;
        r_vq <= mem_valid[rd_set];
    end

    assign o_init = r_clearing;

    // Compare and victim pick.
    logic [MAX_WAYS-1:0] hit_vec, inv_vec;
    logic                hit, has_inv;
    logic [WAY_W-1:0]    hit_way, inv_way, lru_way;
    logic [STAMP_WIDTH-1:0] lru_st;
    always_comb begin
        hit = 1'b0; has_inv = 1'b0;
        hit_way = '0; inv_way = '0; lru_way = '0;
        lru_st = r_stq[0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w] = (w < w_eff) && r_vq[w] && (r_tagq[w] == r_tag);
            inv_vec[w] = (w < w_eff) && !r_vq[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin hit = 1'b1; hit_way = WAY_W'(w); end
            if (inv_vec[w]) begin has_inv = 1'b1; inv_way = WAY_W'(w); end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (w < w_eff && r_stq[w] < lru_st) begin
                lru_st = r_stq[w]; lru_way = WAY_W'(w);
            end
        end
    end

    assign wr_en   = i_cmd.lookup;
    assign wr_way  = hit ? hit_way : (has_inv ? inv_way : lru_way);
    assign wr_mask = MAX_WAYS'(1) << wr_way;

    // Stamps, totals and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            o_hits      <= '0;
            o_misses    <= '0;
            o_evictions <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= i_cmd.lookup;
            if (i_cmd.tick && r_clock != STAMP_MAX) r_clock <= r_clock + 1'b1;
            if (i_cmd.lookup) begin
                if (hit) begin
                    if (o_hits != TOT_MAX) o_hits <= o_hits + 1'b1;
                end else begin
                    if (o_misses != TOT_MAX) o_misses <= o_misses + 1'b1;
                    if (!has_inv && o_evictions != TOT_MAX)
                        o_evictions <= o_evictions + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            o_outcome <= hit ? OUT_HIT : (has_inv ? OUT_FILL : OUT_EVICT);
            o_last    <= i_cmd.last;
        end
    end

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(i_cmd.load || i_cmd.lookup)) else $error("access while clearing");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> o_valid) else $error("result missing");
    a_noload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.lookup)) else $error("load and lookup together");

endmodule

// ===== rtl/core/set_assoc_cache_lru_sim.sv =====
// Set-associative cache LRU simulator, top level.
// Items: a load or store is a set read issued with the access latch, then a compare and
// write back; a modify adds a second set read and a second pass, and strobes a result
// for each pass. Results are registered after each lookup. A new item is taken only when
// the controller is idle again. Results are strobed one cycle and cannot be stalled.
// Synchronous reset clears the totals and the access clock; busy then stays high while
// the valid store is cleared one set per cycle.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sac_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = sac_pkg::DEF_STAMP_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [63:0]                 i_address,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output logic [1:0]                  o_outcome,
    output logic                        o_last,
    output logic [31:0]                 o_hits_so_far,
    output logic [31:0]                 o_misses_so_far,
    output logic [31:0]                 o_evictions_so_far
);
    import sac_pkg::*;

    t_dp_cmd cmd;
    logic    init;

    sac_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_command, .i_init(init),
        .o_busy(busy), .o_cmd(cmd)
    );

    sac_dp #(
        .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .STAMP_WIDTH(STAMP_WIDTH)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_address,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_init(init),
        .o_valid(o_strobe), .o_outcome, .o_last,
        .o_hits(o_hits_so_far), .o_misses(o_misses_so_far),
        .o_evictions(o_evictions_so_far)
    );

endmodule
